// ===== rtl/hhsp_pkg.sv =====
// Package with the key ROM, codes and helper functions of the HTTP header parser.
package hhsp_pkg;

	localparam int unsigned ROM_KEYS = 28;
	localparam int unsigned ROM_KEY_BYTES = 32;
	localparam int unsigned DEF_NUM_KEYS = 28;
	localparam int unsigned DEF_MAX_KEY_LEN = 32;
	localparam int unsigned CL_INDEX = 1;

	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [1:0] SHORT_LINE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_NO_END = 2'd2;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		PH_STATUS = 3'b001,
		PH_HEADER = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef enum logic [3:0] {
		CM_WAIT   = 4'b0001,
		CM_SKIP   = 4'b0010,
		CM_DIGITS = 4'b0100,
		CM_DONE   = 4'b1000
	} code_mode_t;

	typedef enum logic [2:0] {
		LC_IDLE   = 3'b001,
		LC_SKIP   = 3'b010,
		LC_DIGITS = 3'b100
	} len_mode_t;

	// Classified byte handed from the front part to the back part.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       is_nl;
		logic       is_digit;
		logic       is_space;
		logic       is_colon;
	} byte_cls_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  header_id;
		logic [7:0]  header_line;
		logic [15:0] status_code;
		logic [31:0] content_length;
		logic [7:0]  line_count;
		logic [31:0] body_length;
		logic [1:0]  status;
		logic        last_of_run;
	} result_t;

	function automatic logic [8*ROM_KEY_BYTES-1:0] key_str(input int unsigned k);
		logic [8*ROM_KEY_BYTES-1:0] s;
		s = '0;
		case (k)
			0: s = "content-type";
			1: s = "content-length";
			2: s = "connection";
			3: s = "server";
			4: s = "date";
			5: s = "cache-control";
			6: s = "node-code";
			7: s = "set-cookie";
			8: s = "x-powered-by";
			9: s = "content-encoding";
			10: s = "sec-websocket-key";
			11: s = "upgrade";
			12: s = "access-control-allow-origin";
			13: s = "access-control-allow-credentials";
			14: s = "access-control-allow-headers";
			15: s = "sec-websocket-accept";
			16: s = "host";
			17: s = "user-agent";
			18: s = "sec-websocket-version";
			19: s = "sec-websocket-protocol";
			20: s = "accept";
			21: s = "accept-encoding";
			22: s = "accept-language";
			23: s = "x-aspnet-version";
			24: s = "sec-websocket-extensions";
			25: s = "pragma";
			26: s = "origin";
			27: s = "upgrade-insecure-requests";
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic int unsigned key_len(input int unsigned k);
		logic [8*ROM_KEY_BYTES-1:0] s;
		int unsigned n;
		s = key_str(k);
		n = 0;
		for (int i = 0; i < ROM_KEY_BYTES; i++) begin
			if (s[8*i +: 8] != 8'h00) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

	// Byte at position p of key k, zero beyond its end.
	function automatic logic [7:0] key_char(input int unsigned k, input int unsigned p);
		int unsigned n;
		logic [8*ROM_KEY_BYTES-1:0] s;
		n = key_len(k);
		s = key_str(k);
		if (p >= n) begin
			return 8'h00;
		end
		return s[8*(n-1-p) +: 8];
	endfunction

endpackage

// ===== rtl/hhsp_front.sv =====
// Front part: accepts bytes, classifies them and fills a two-entry queue.
module hhsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                q_valid,
	input  logic                q_pop,
	output hhsp_pkg::byte_cls_t q_item
);
	import hhsp_pkg::*;

	byte_cls_t mem_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] count_q;
	logic      push;
	logic      pop;
	byte_cls_t cls;

	always_comb begin
		cls.ch       = data_byte;
		cls.last     = last_byte;
		cls.is_nl    = (data_byte == CH_NL);
		cls.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		cls.is_space = (data_byte == CH_SPACE);
		cls.is_colon = (data_byte == CH_COLON);
	end

	assign stall = (count_q == 2'd2);
	assign push = valid && !stall;
	assign pop = q_pop && (count_q != 2'd0);
	assign q_valid = (count_q != 2'd0);
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> stall) else $error("full queue not stalling");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid || !pop) else $error("pop from empty queue");

endmodule

// ===== rtl/hhsp_back.sv =====
// Back part: runs the parse state and drives the result register with a skid slot.
module hhsp_back #(
	parameter int unsigned NUM_KEYS = hhsp_pkg::DEF_NUM_KEYS,
	parameter int unsigned MAX_KEY_LEN = hhsp_pkg::DEF_MAX_KEY_LEN
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  hhsp_pkg::byte_cls_t q_item,
	output logic                out_valid,
	input  logic                out_stall,
	output hhsp_pkg::result_t   out_res
);
	import hhsp_pkg::*;

	localparam int unsigned USE_KEYS = (NUM_KEYS < ROM_KEYS) ? NUM_KEYS : ROM_KEYS;
	localparam int unsigned POS_W = $clog2(MAX_KEY_LEN + 2);

	function automatic logic [NUM_KEYS-1:0] full_mask();
		logic [NUM_KEYS-1:0] m;
		m = '0;
		for (int k = 0; k < USE_KEYS; k++) begin
			if (key_len(k) <= MAX_KEY_LEN) begin
				m[k] = 1'b1;
			end
		end
		return m;
	endfunction

	localparam logic [NUM_KEYS-1:0] FULL_MASK = full_mask();

	phase_t              phase_q, phase_d;
	code_mode_t          cmode_q, cmode_d;
	len_mode_t           lmode_q, lmode_d;
	logic [15:0]         code_q, code_d;
	logic [1:0]          bsn_q, bsn_d;
	logic [7:0]          lines_q, lines_d;
	logic [NUM_KEYS-1:0] mask_q, mask_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic                colon_q, colon_d;
	logic [31:0]         len_q, len_d;
	logic [31:0]         body_q, body_d;
	logic                err_q, err_d;

	result_t             res0, res1;
	logic [1:0]          nres;
	result_t             slot_q [2];
	logic [1:0]          cnt_q;
	logic                head_q;
	logic                take;
	logic                deq;

	logic [7:0]          lc;
	logic [3:0]          dig;
	logic [19:0]         code_x10;
	logic [35:0]         len_x10;
	logic                hit;
	logic [4:0]          hit_id;
	logic [NUM_KEYS-1:0] len_eq;

	assign take = q_valid && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && deq));
	assign q_pop = take;
	assign dig = q_item.ch[3:0];
	assign code_x10 = {4'd0, code_q} * 20'd10 + {16'd0, dig};
	assign len_x10 = {4'd0, len_q} * 36'd10 + {32'd0, dig};
	assign lc = ((q_item.ch >= CH_UPPER_A) && (q_item.ch <= CH_UPPER_Z)) ?
		q_item.ch + 8'h20 : q_item.ch;

	always_comb begin
		hit = 1'b0;
		hit_id = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			len_eq[k] = (k < USE_KEYS) && (int'(pos_q) == key_len(k));
			if (mask_q[k] && len_eq[k]) begin
				hit = 1'b1;
				hit_id = 5'(k);
			end
		end
	end

	always_comb begin
		phase_d = phase_q; cmode_d = cmode_q; lmode_d = lmode_q;
		code_d = code_q; bsn_d = bsn_q; lines_d = lines_q;
		mask_d = mask_q; pos_d = pos_q; colon_d = colon_q;
		len_d = len_q; body_d = body_q; err_d = err_q;
		res0 = '0; res1 = '0; nres = 2'd0;

		if (phase_q == PH_BODY) begin
			if (body_q != 32'hFFFF_FFFF) begin
				body_d = body_q + 32'd1;
			end
		end else if (q_item.is_nl) begin
			cmode_d = CM_DONE;
			if (bsn_q < SHORT_LINE) begin
				phase_d = PH_BODY;
				lmode_d = LC_IDLE;
			end else begin
				if (lines_q != 8'd255) begin
					lines_d = lines_q + 8'd1;
				end
				bsn_d = 2'd1;
				phase_d = PH_HEADER;
				mask_d = FULL_MASK;
				pos_d = '0;
				colon_d = 1'b0;
				lmode_d = LC_IDLE;
			end
		end else begin
			if (bsn_q < SHORT_LINE) begin
				bsn_d = bsn_q + 2'd1;
			end
			if (phase_q == PH_STATUS) begin
				unique case (cmode_q)
					CM_WAIT: begin
						if (q_item.is_space) cmode_d = CM_SKIP;
					end
					CM_SKIP: begin
						if (q_item.is_digit) begin
							code_d = {12'd0, dig};
							cmode_d = CM_DIGITS;
						end else if (!q_item.is_space) begin
							cmode_d = CM_DONE;
						end
					end
					CM_DIGITS: begin
						if (q_item.is_digit) begin
							code_d = (code_x10[19:16] != 4'd0) ? 16'hFFFF : code_x10[15:0];
						end else begin
							cmode_d = CM_DONE;
						end
					end
					default: begin
					end
				endcase
			end else begin
				unique case (lmode_q)
					LC_SKIP: begin
						if (q_item.is_digit) begin
							len_d = {28'd0, dig};
							lmode_d = LC_DIGITS;
						end else if (!q_item.is_space) begin
							lmode_d = LC_IDLE;
						end
					end
					LC_DIGITS: begin
						if (q_item.is_digit) begin
							len_d = (len_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : len_x10[31:0];
						end else begin
							lmode_d = LC_IDLE;
						end
					end
					default: begin
					end
				endcase
				if (!colon_q && !err_q) begin
					if (q_item.is_colon) begin
						colon_d = 1'b1;
						if (hit && (int'(pos_q) <= MAX_KEY_LEN)) begin
							if ((int'(hit_id) == CL_INDEX) && (len_q == 32'd0)) begin
								lmode_d = LC_SKIP;
							end
							res0.kind = KIND_HEADER;
							res0.header_id = hit_id;
							res0.header_line = lines_q;
							nres = 2'd1;
						end else begin
							err_d = 1'b1;
						end
					end else begin
						for (int k = 0; k < NUM_KEYS; k++) begin
							if ((k < USE_KEYS) &&
								((int'(pos_q) >= key_len(k)) || (key_char(k, pos_q) != lc))) begin
								mask_d[k] = 1'b0;
							end
						end
						if (int'(pos_q) <= MAX_KEY_LEN) begin
							pos_d = pos_q + 1'b1;
						end
					end
				end
			end
		end

		if (q_item.last) begin
			res1.kind = KIND_SUMMARY;
			res1.status_code = code_d;
			res1.content_length = err_d ? 32'd0 : len_d;
			res1.line_count = lines_d;
			res1.body_length = body_d;
			res1.status = err_d ? ST_UNKNOWN : ((phase_d != PH_BODY) ? ST_NO_END : ST_OK);
			res1.last_of_run = 1'b1;
			if (nres == 2'd0) begin
				res0 = res1;
			end
			nres = nres + 2'd1;
			phase_d = PH_STATUS; cmode_d = CM_WAIT; lmode_d = LC_IDLE;
			code_d = '0; bsn_d = '0; lines_d = '0; mask_d = FULL_MASK;
			pos_d = '0; colon_d = 1'b0; len_d = '0; body_d = '0; err_d = 1'b0;
		end else if (nres != 2'd0) begin
			res0.last_of_run = 1'b1;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_res = slot_q[head_q];
	assign deq = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (take && (nres != 2'd0)) begin
			slot_q[0] <= res0;
			slot_q[1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STATUS; cmode_q <= CM_WAIT; lmode_q <= LC_IDLE;
			code_q <= '0; bsn_q <= '0; lines_q <= '0; mask_q <= FULL_MASK;
			pos_q <= '0; colon_q <= 1'b0; len_q <= '0; body_q <= '0; err_q <= 1'b0;
			cnt_q <= 2'd0; head_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d; cmode_q <= cmode_d; lmode_q <= lmode_d;
				code_q <= code_d; bsn_q <= bsn_d; lines_q <= lines_d; mask_q <= mask_d;
				pos_q <= pos_d; colon_q <= colon_d; len_q <= len_d;
				body_q <= body_d; err_q <= err_d;
				cnt_q <= nres;
				head_q <= 1'b0;
			end else if (deq) begin
				cnt_q <= cnt_q - 2'd1;
				head_q <= 1'b1;
			end
		end
	end

	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (cnt_q == 2'd0) || ((cnt_q == 2'd1) && deq))
		else $error("byte taken over pending results");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (cnt_q == 2'd1)) |-> out_res.last_of_run)
		else $error("final result lacks last_of_run");
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && q_item.last) |=> (phase_q == PH_STATUS) && !err_q)
		else $error("state not cleared after last byte");

endmodule

// ===== rtl/http_header_stream_parser.sv =====
// Top level of the HTTP header stream parser.
//  channel | direction | handshake       | payload
//  input   | in        | valid / stall   | data_byte, last_byte
//  output  | out       | out_valid/out_stall | kind .. last_of_run
// One byte is taken per cycle while stall is low; the back part takes a byte when its
// result slots are empty or their last result leaves in the same cycle, so a byte with
// two results holds the next byte. A byte enters a two-entry queue, then the result slots.
// Reset arst_n clears all parse state; no clearing pass is needed.
// Output stalls fill the queue, then raise stall on the input.
module http_header_stream_parser #(
	parameter int unsigned NUM_KEYS = hhsp_pkg::DEF_NUM_KEYS,
	parameter int unsigned MAX_KEY_LEN = hhsp_pkg::DEF_MAX_KEY_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [4:0]  header_id,
	output logic [7:0]  header_line,
	output logic [15:0] status_code,
	output logic [31:0] content_length,
	output logic [7:0]  line_count,
	output logic [31:0] body_length,
	output logic [1:0]  status,
	output logic        last_of_run
);
	import hhsp_pkg::*;

	logic      q_valid;
	logic      q_pop;
	byte_cls_t q_item;
	result_t   res;

	hhsp_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	hhsp_back #(.NUM_KEYS(NUM_KEYS), .MAX_KEY_LEN(MAX_KEY_LEN)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_res(res)
	);

	assign kind = res.kind;
	assign header_id = res.header_id;
	assign header_line = res.header_line;
	assign status_code = res.status_code;
	assign content_length = res.content_length;
	assign line_count = res.line_count;
	assign body_length = res.body_length;
	assign status = res.status;
	assign last_of_run = res.last_of_run;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the HTTP header stream parser with a built-in byte-level predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hhsp_pkg::*;

	class parse_scoreboard;
		result_t pending[$];
		int errors;
		phase_t ph;
		code_mode_t cmode;
		len_mode_t lmode;
		logic [15:0] code_acc;
		logic [1:0] since_nl;
		logic [7:0] lines;
		logic [27:0] cand;
		int unsigned name_pos;
		bit colon;
		logic [31:0] len_val;
		logic [31:0] body_cnt;
		bit err;

		function void clear();
			ph = PH_STATUS;
			cmode = CM_WAIT;
			code_acc = '0;
			since_nl = '0;
			lines = '0;
			len_val = '0;
			body_cnt = '0;
			err = 0;
			line_clear();
		endfunction

		function void line_clear();
			cand = '1;
			name_pos = 0;
			colon = 0;
			lmode = LC_IDLE;
		endfunction

		function automatic logic [31:0] dec_step(logic [31:0] acc, logic [7:0] c,
				longint unsigned top);
			longint unsigned v;
			v = longint'(acc) * 10 + (c - CH_ZERO);
			return (v > top) ? top[31:0] : v[31:0];
		endfunction

		function void header_step(logic [7:0] c);
			result_t r;
			bit dig;
			dig = (c >= CH_ZERO && c <= CH_NINE);
			if (lmode == LC_SKIP) begin
				if (dig) begin
					len_val = c - CH_ZERO;
					lmode = LC_DIGITS;
				end else if (c != CH_SPACE) begin
					lmode = LC_IDLE;
				end
			end else if (lmode == LC_DIGITS) begin
				if (dig) len_val = dec_step(len_val, c, 64'hFFFF_FFFF);
				else lmode = LC_IDLE;
			end
			if (colon || err) return;
			if (c == CH_COLON) begin
				colon = 1;
				if (name_pos <= 32) begin
					for (int k = 0; k < 28; k++) begin
						if (cand[k] && key_len(k) == name_pos) begin
							if (k == CL_INDEX && len_val == 0) lmode = LC_SKIP;
							r = '0;
							r.kind = KIND_HEADER;
							r.header_id = 5'(k);
							r.header_line = lines;
							pending.push_back(r);
							return;
						end
					end
				end
				err = 1;
				return;
			end
			if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + 8'h20;
			for (int k = 0; k < 28; k++)
				if (cand[k] && (name_pos >= key_len(k) || key_char(k, name_pos) != c))
					cand[k] = 0;
			if (name_pos <= 32) name_pos++;
		endfunction

		function void note_byte(logic [7:0] c, logic last);
			result_t r;
			int n_prior;
			bit dig;
			n_prior = pending.size();
			dig = (c >= CH_ZERO && c <= CH_NINE);
			if (ph == PH_BODY) begin
				if (body_cnt != 32'hFFFF_FFFF) body_cnt++;
			end else if (c == CH_NL) begin
				cmode = CM_DONE;
				if (since_nl < SHORT_LINE) begin
					ph = PH_BODY;
					lmode = LC_IDLE;
				end else begin
					if (lines != 8'hFF) lines++;
					since_nl = 1;
					ph = PH_HEADER;
					line_clear();
				end
			end else begin
				if (since_nl < SHORT_LINE) since_nl++;
				if (ph == PH_STATUS) begin
					case (cmode)
						CM_WAIT: if (c == CH_SPACE) cmode = CM_SKIP;
						CM_SKIP: begin
							if (dig) begin
								code_acc = c - CH_ZERO;
								cmode = CM_DIGITS;
							end else if (c != CH_SPACE) begin
								cmode = CM_DONE;
							end
						end
						CM_DIGITS: begin
							if (dig) code_acc = 16'(dec_step({16'd0, code_acc}, c, 65535));
							else cmode = CM_DONE;
						end
						default: ;
					endcase
				end else begin
					header_step(c);
				end
			end
			if (last) begin
				r = '0;
				r.kind = KIND_SUMMARY;
				r.status_code = code_acc;
				r.content_length = err ? '0 : len_val;
				r.line_count = lines;
				r.body_length = body_cnt;
				r.status = err ? ST_UNKNOWN : (ph != PH_BODY ? ST_NO_END : ST_OK);
				pending.push_back(r);
				clear();
			end
			if (pending.size() > n_prior) pending[pending.size() - 1].last_of_run = 1;
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result kind=%0d", got.kind);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.kind != e.kind) begin
				$error("kind: expected %0d, actual %0d", e.kind, got.kind); errors++; end
			if (got.header_id != e.header_id) begin
				$error("header_id: expected %0d, actual %0d", e.header_id, got.header_id);
				errors++; end
			if (got.header_line != e.header_line) begin
				$error("header_line: expected %0d, actual %0d", e.header_line,
					got.header_line); errors++; end
			if (got.status_code != e.status_code) begin
				$error("status_code: expected %0d, actual %0d", e.status_code,
					got.status_code); errors++; end
			if (got.content_length != e.content_length) begin
				$error("content_length: expected %0d, actual %0d", e.content_length,
					got.content_length); errors++; end
			if (got.line_count != e.line_count) begin
				$error("line_count: expected %0d, actual %0d", e.line_count,
					got.line_count); errors++; end
			if (got.body_length != e.body_length) begin
				$error("body_length: expected %0d, actual %0d", e.body_length,
					got.body_length); errors++; end
			if (got.status != e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status); errors++; end
			if (got.last_of_run != e.last_of_run) begin
				$error("last_of_run: expected %0d, actual %0d", e.last_of_run,
					got.last_of_run); errors++; end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic valid;
	logic stall;
	logic [7:0] data_byte;
	logic last_byte;
	logic out_valid;
	logic out_stall;
	logic kind;
	logic [4:0] header_id;
	logic [7:0] header_line;
	logic [15:0] status_code;
	logic [31:0] content_length;
	logic [7:0] line_count;
	logic [31:0] body_length;
	logic [1:0] status;
	logic last_of_run;

	parse_scoreboard sb;
	byte unsigned msg[$];
	bit quiet;
	int cycles;
	int sent;

	http_header_stream_parser i_dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({kind, header_id, header_line, status_code, content_length,
				line_count, body_length, status, last_of_run});
	end

	initial begin
		out_stall <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic send_byte(input byte unsigned c, input bit last);
		if (!quiet && $urandom_range(0, 15) == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		valid <= 1'b1;
		data_byte <= c;
		last_byte <= last;
		@(posedge clk);
		while (stall) @(posedge clk);
		sb.note_byte(c, last);
		sent++;
	endtask

	task automatic send_msg();
		foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
		msg.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
	endtask

	task automatic add_name(input int unsigned k);
		int unsigned n;
		byte unsigned c;
		n = key_len(k);
		for (int unsigned p = 0; p < n; p++) begin
			c = key_char(k, p);
			if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'h20;
			msg.push_back(c);
		end
	endtask

	task automatic add_num(input int digits);
		for (int i = 0; i < digits; i++) msg.push_back(8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic add_random_msg();
		int nh;
		int r;
		if ($urandom_range(0, 1)) add_str("HTTP/1.1");
		else add_str("GET /x");
		if ($urandom_range(0, 3) == 0) add_str("   ");
		else add_str(" ");
		add_num($urandom_range(0, 6));
		if ($urandom_range(0, 3) == 0) msg.push_back(8'($urandom_range(0, 255)));
		add_str(" OK\n");
		nh = $urandom_range(0, 4);
		for (int h = 0; h < nh; h++) begin
			r = $urandom_range(0, 9);
			if (r < 6) add_name($urandom_range(0, 27));
			else if (r < 8) add_name(CL_INDEX);
			else if (r == 8) add_str("x-bogus");
			else msg.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 7) != 0) msg.push_back(CH_COLON);
			if ($urandom_range(0, 1)) add_str(" ");
			add_num($urandom_range(0, 11));
			msg.push_back(CH_NL);
		end
		if ($urandom_range(0, 5) != 0) msg.push_back(CH_NL);
		r = $urandom_range(0, 10);
		for (int i = 0; i < r; i++) msg.push_back(8'($urandom_range(0, 255)));
		if (msg.size() == 0) msg.push_back(CH_NL);
	endtask

	initial begin
		sb = new();
		sb.clear();
		quiet = 0;
		sent = 0;
		valid <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: short newline at once, saturations, all keys, unknown and colon cases.
		add_str("\n"); send_msg();
		add_str("HTTP 99999999 X\nContent-Length: 99999999999\n\nAB"); send_msg();
		add_str("R  200\nHost:1\n:x\nCONTENT-LENGTH: 0\n\nz"); send_msg();
		add_str("S :-\nabcdefghijklmnopqrstuvwxyzabcdefghijk:1\nhost:\n\n"); send_msg();
		add_str("HTTP 404\n");
		for (int k = 0; k < 28; k++) begin
			add_name(k);
			add_str(":\n");
		end
		add_str("\n");
		msg.push_back(8'hFF); msg.push_back(8'h00); send_msg();
		add_str("A 1\nnocolon line\ncontent-length: 7\ncontent-length: 9\n"); send_msg();
		while (sent < 950) begin
			if ($urandom_range(0, 9) == 0) begin
				msg.push_back(8'($urandom_range(0, 255)));
				send_byte(msg[0], $urandom_range(0, 3) == 0);
				msg.delete();
			end else begin
				add_random_msg();
				if (sent > 850) quiet = 1;
				send_msg();
			end
		end
		valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
